// ----- rtl/core/mcgm_pkg.sv -----
// Shared types and constants for the MIDI CC gain/mute filter.
package mcgm_pkg;

   localparam logic [7:0]  STATUS_MASK   = 8'hf0;
   localparam logic [7:0]  STATUS_CC     = 8'hb0;
   localparam logic [6:0]  CC_PAN        = 7'd10;
   localparam logic [6:0]  CC_EXPRESSION = 7'd11;
   localparam logic [6:0]  CC_MUTE       = 7'h2e;
   localparam logic [6:0]  CC_GAIN_FIRST = 7'h2f;
   localparam logic [6:0]  CC_GAIN_LAST  = 7'h32;
   localparam logic [6:0]  LEVEL_MAX     = 7'd127;

   localparam int          GAIN_COUNT    = 4;
   localparam int          GAIN_IDX_W    = 2;

   localparam int          PROD_W        = 28;
   localparam int          MUL_B_W       = 8;
   localparam int          MUL_P_W       = PROD_W + MUL_B_W;
   localparam logic [PROD_W-1:0] LEVEL_DIV = 28'h1f417f;
   localparam int          RECIP_SHIFT   = PROD_W;
   localparam logic [MUL_B_W-1:0] RECIP_MULT =
      MUL_B_W'((64'd1 << RECIP_SHIFT) / 64'(LEVEL_DIV));

   localparam logic [0:0]  CSR_CHANNEL   = 1'b0;
   localparam logic [0:0]  CSR_OWNS_PAN  = 1'b1;

   typedef enum logic [1:0] {
      KIND_PASS,
      KIND_DROP,
      KIND_GAIN,
      KIND_MUTE
   } kind_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_G01,
      MUL_G2,
      MUL_G3,
      MUL_RECIP,
      MUL_BACK
   } mul_op_type;

   typedef enum logic [1:0] {
      FIN_NONE,
      FIN_PASS,
      FIN_GAIN,
      FIN_MUTE
   } fin_op_type;

   typedef struct packed {
      logic       load;
      logic       gain_wr;
      mul_op_type mul_op;
      fin_op_type fin_op;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     out_busy;
   } stat_type;

endpackage

// ----- rtl/core/mcgm_ctrl.sv -----
// Controller state machine: sequences decode, the shared multiplier and result write.
module mcgm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output mcgm_pkg::cmd_type cmd,
   input  mcgm_pkg::stat_type stat
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_G01,
      S_G2,
      S_G3,
      S_RECIP,
      S_BACK,
      S_FINISH
   } state_type;

   state_type          state_ff, state_in;
   mcgm_pkg::kind_type kind_ff, kind_in;

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      req_tready  = 1'b0;
      cmd.load    = 1'b0;
      cmd.gain_wr = 1'b0;
      cmd.mul_op  = mcgm_pkg::MUL_NONE;
      cmd.fin_op  = mcgm_pkg::FIN_NONE;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            kind_in = stat.kind;
            unique case (stat.kind)
               mcgm_pkg::KIND_DROP: state_in = S_IDLE;
               mcgm_pkg::KIND_GAIN: begin
                  cmd.gain_wr = 1'b1;
                  state_in    = S_G01;
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_G01: begin
            cmd.mul_op = mcgm_pkg::MUL_G01;
            state_in   = S_G2;
         end
         S_G2: begin
            cmd.mul_op = mcgm_pkg::MUL_G2;
            state_in   = S_G3;
         end
         S_G3: begin
            cmd.mul_op = mcgm_pkg::MUL_G3;
            state_in   = S_RECIP;
         end
         S_RECIP: begin
            cmd.mul_op = mcgm_pkg::MUL_RECIP;
            state_in   = S_BACK;
         end
         S_BACK: begin
            cmd.mul_op = mcgm_pkg::MUL_BACK;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (!stat.out_busy) begin
               case (kind_ff)
                  mcgm_pkg::KIND_GAIN: cmd.fin_op = mcgm_pkg::FIN_GAIN;
                  mcgm_pkg::KIND_MUTE: cmd.fin_op = mcgm_pkg::FIN_MUTE;
                  default:             cmd.fin_op = mcgm_pkg::FIN_PASS;
               endcase
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= mcgm_pkg::KIND_PASS;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

// ----- rtl/core/mcgm_dpath.sv -----
// Datapath: message capture, gain store, shared multiplier, level divide and output register.
module mcgm_dpath (
   input  logic               clock,
   input  logic               reset,
   input  mcgm_pkg::cmd_type  cmd,
   output mcgm_pkg::stat_type stat,
   input  logic [7:0]         in_status,
   input  logic [6:0]         in_data_one,
   input  logic [6:0]         in_data_two,
   input  logic               csr_we,
   input  logic [0:0]         csr_addr,
   input  logic [3:0]         csr_wdata,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [7:0]         out_status,
   output logic [6:0]         out_data_one,
   output logic [6:0]         out_data_two
);

   logic [7:0] status_ff;
   logic [6:0] d1_ff, d2_ff;

   logic [3:0] channel_ff;
   logic       owns_pan_ff;

   logic [6:0] gain_ff [mcgm_pkg::GAIN_COUNT];
   logic [6:0] level_ff;
   logic       muted_ff;

   logic [mcgm_pkg::MUL_P_W-1:0] mres_ff, mres_in;
   logic [mcgm_pkg::PROD_W-1:0]  prod_ff;
   logic [6:0]                   est_ff;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_status_ff;
   logic [6:0] out_d1_ff, out_d2_ff;

   logic [6:0]                      gain_off;
   logic [mcgm_pkg::GAIN_IDX_W-1:0] gain_idx;
   logic [mcgm_pkg::PROD_W-1:0]     mul_a;
   logic [mcgm_pkg::MUL_B_W-1:0]    mul_b;
   logic [mcgm_pkg::PROD_W-1:0]     rem;
   logic [6:0]                      level_calc;
   logic                            gain_emit;
   logic                            mute_now;
   logic                            emit;
   logic [7:0]                      expr_status;
   logic [6:0]                      emit_d2;

   // message classification
   always_comb begin
      stat.out_busy = out_valid_ff;
      if ((status_ff & mcgm_pkg::STATUS_MASK) != mcgm_pkg::STATUS_CC) begin
         stat.kind = mcgm_pkg::KIND_PASS;
      end else if (d1_ff >= mcgm_pkg::CC_GAIN_FIRST && d1_ff <= mcgm_pkg::CC_GAIN_LAST) begin
         stat.kind = mcgm_pkg::KIND_GAIN;
      end else if (d1_ff == mcgm_pkg::CC_MUTE) begin
         stat.kind = mcgm_pkg::KIND_MUTE;
      end else if (d1_ff == mcgm_pkg::CC_EXPRESSION) begin
         stat.kind = mcgm_pkg::KIND_DROP;
      end else if (d1_ff == mcgm_pkg::CC_PAN && owns_pan_ff) begin
         stat.kind = mcgm_pkg::KIND_DROP;
      end else begin
         stat.kind = mcgm_pkg::KIND_PASS;
      end
   end

   assign gain_off = d1_ff - mcgm_pkg::CC_GAIN_FIRST;
   assign gain_idx = gain_off[mcgm_pkg::GAIN_IDX_W-1:0];

   // shared 28x8 multiplier operand select
   always_comb begin
      mul_a = mres_ff[mcgm_pkg::PROD_W-1:0];
      mul_b = '0;
      case (cmd.mul_op)
         mcgm_pkg::MUL_G01: begin
            mul_a = mcgm_pkg::PROD_W'(gain_ff[0]);
            mul_b = mcgm_pkg::MUL_B_W'(gain_ff[1]);
         end
         mcgm_pkg::MUL_G2:    mul_b = mcgm_pkg::MUL_B_W'(gain_ff[2]);
         mcgm_pkg::MUL_G3:    mul_b = mcgm_pkg::MUL_B_W'(gain_ff[3]);
         mcgm_pkg::MUL_RECIP: mul_b = mcgm_pkg::RECIP_MULT;
         mcgm_pkg::MUL_BACK: begin
            mul_a = mcgm_pkg::LEVEL_DIV;
            mul_b = mcgm_pkg::MUL_B_W'(mres_ff[mcgm_pkg::RECIP_SHIFT+6:mcgm_pkg::RECIP_SHIFT]);
         end
         default: ;
      endcase
   end

   assign mres_in = mcgm_pkg::MUL_P_W'(mul_a) * mcgm_pkg::MUL_P_W'(mul_b);

   // estimate is floor or one short; one compare fixes it
   assign rem        = prod_ff - mres_ff[mcgm_pkg::PROD_W-1:0];
   assign level_calc = est_ff + 7'(rem >= mcgm_pkg::LEVEL_DIV);
   assign gain_emit  = (level_calc != level_ff) && !muted_ff;
   assign mute_now   = (d2_ff != 7'd0);
   assign expr_status = mcgm_pkg::STATUS_CC | {4'd0, channel_ff};

   always_comb begin
      emit    = 1'b0;
      emit_d2 = d2_ff;
      case (cmd.fin_op)
         mcgm_pkg::FIN_PASS: emit = 1'b1;
         mcgm_pkg::FIN_GAIN: begin
            emit    = gain_emit;
            emit_d2 = level_calc;
         end
         mcgm_pkg::FIN_MUTE: begin
            emit    = (muted_ff != mute_now);
            emit_d2 = mute_now ? 7'd0 : level_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_ff   <= '0;
         owns_pan_ff  <= 1'b0;
         for (int i = 0; i < mcgm_pkg::GAIN_COUNT; i++) begin
            gain_ff[i] <= mcgm_pkg::LEVEL_MAX;
         end
         level_ff     <= mcgm_pkg::LEVEL_MAX;
         muted_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               mcgm_pkg::CSR_CHANNEL:  channel_ff  <= csr_wdata;
               mcgm_pkg::CSR_OWNS_PAN: owns_pan_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (cmd.gain_wr) begin
            gain_ff[gain_idx] <= d2_ff;
         end
         if (cmd.fin_op == mcgm_pkg::FIN_GAIN && gain_emit) begin
            level_ff <= level_calc;
         end
         if (cmd.fin_op == mcgm_pkg::FIN_MUTE) begin
            muted_ff <= mute_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         status_ff <= in_status;
         d1_ff     <= in_data_one;
         d2_ff     <= in_data_two;
      end
      if (cmd.mul_op != mcgm_pkg::MUL_NONE) begin
         mres_ff <= mres_in;
      end
      if (cmd.mul_op == mcgm_pkg::MUL_RECIP) begin
         prod_ff <= mres_ff[mcgm_pkg::PROD_W-1:0];
      end
      if (cmd.mul_op == mcgm_pkg::MUL_BACK) begin
         est_ff <= mres_ff[mcgm_pkg::RECIP_SHIFT+6:mcgm_pkg::RECIP_SHIFT];
      end
      if (emit) begin
         if (cmd.fin_op == mcgm_pkg::FIN_PASS) begin
            out_status_ff <= status_ff;
            out_d1_ff     <= d1_ff;
         end else begin
            out_status_ff <= expr_status;
            out_d1_ff     <= mcgm_pkg::CC_EXPRESSION;
         end
         out_d2_ff <= emit_d2;
      end
   end

   assign out_valid    = out_valid_ff;
   assign out_status   = out_status_ff;
   assign out_data_one = out_d1_ff;
   assign out_data_two = out_d2_ff;

endmodule

// ----- rtl/core/midi_cc_gain_mute_filter.sv -----
// Top level of the MIDI CC gain/mute filter.
// Pass-through and mute transactions run through decode and finish; dropped ones end
// at decode; gain transactions add five steps on one shared 28x8 multiplier.
// Transactions are handled one at a time; finish waits while a result is still unsent,
// and the next transaction is accepted while a result waits in the output register.
// Reset (synchronous, active high): gains and level 127, unmuted, channel 0, pan not owned.
module midi_cc_gain_mute_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // status_byte[7:0], data_one[14:8], data_two[21:15]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // out_status[7:0], out_data_one[14:8], out_data_two[21:15]
   input  logic        csr_we,
   input  logic [0:0]  csr_addr,
   input  logic [3:0]  csr_wdata
);

   mcgm_pkg::cmd_type  cmd;
   mcgm_pkg::stat_type stat;
   logic [7:0]         out_status;
   logic [6:0]         out_data_one;
   logic [6:0]         out_data_two;

   mcgm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   mcgm_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .in_status    (req_tdata[7:0]),
      .in_data_one  (req_tdata[14:8]),
      .in_data_two  (req_tdata[21:15]),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_status   (out_status),
      .out_data_one (out_data_one),
      .out_data_two (out_data_two)
   );

   assign rsp_tdata = {2'b00, out_data_two, out_data_one, out_status};

endmodule

// ----- tb/mcgm_checker.sv -----
// Checker for the MIDI CC gain/mute filter: predicts each result and compares it on arrival.
`timescale 1ns / 1ps

module mcgm_checker
   import mcgm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,  // status_byte[7:0], data_one[14:8], data_two[21:15]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,  // out_status[7:0], out_data_one[14:8], out_data_two[21:15]
   input  logic        csr_we,
   input  logic [0:0]  csr_addr,
   input  logic [3:0]  csr_wdata,
   output int          error_count,
   output int          pending_count,
   output int          result_count
);

   typedef struct packed {
      logic [6:0] data_two;
      logic [6:0] data_one;
      logic [7:0] status;
   } midi_msg_t;

   logic [6:0] gains [GAIN_COUNT];
   logic [6:0] level;
   logic       muted;
   logic [3:0] channel;
   logic       pan_owned;

   midi_msg_t  expected_msgs [$];
   int         errors;
   int         results;

   initial begin
      error_count   = 0;
      pending_count = 0;
      result_count  = 0;
      errors        = 0;
      results       = 0;
   end

   task automatic clear_state();
      for (int i = 0; i < GAIN_COUNT; i++) gains[i] = LEVEL_MAX;
      level     = LEVEL_MAX;
      muted     = 1'b0;
      channel   = 4'd0;
      pan_owned = 1'b0;
      expected_msgs.delete();
   endtask

   function automatic midi_msg_t expression_msg(logic [6:0] value);
      midi_msg_t m;
      m.status   = STATUS_CC | {4'd0, channel};
      m.data_one = CC_EXPRESSION;
      m.data_two = value;
      return m;
   endfunction

   task automatic predict_message(input midi_msg_t in_msg);
      logic [27:0] prod;
      logic [6:0]  new_level;
      logic        now_muted;
      if ((in_msg.status & STATUS_MASK) != STATUS_CC) begin
         expected_msgs.push_back(in_msg);
      end else if (in_msg.data_one >= CC_GAIN_FIRST && in_msg.data_one <= CC_GAIN_LAST) begin
         gains[2'(in_msg.data_one - CC_GAIN_FIRST)] = in_msg.data_two;
         prod = 28'(gains[0]) * 28'(gains[1]) * 28'(gains[2]) * 28'(gains[3]);
         new_level = 7'(prod / LEVEL_DIV);
         if (new_level != level && !muted) begin
            level = new_level;
            expected_msgs.push_back(expression_msg(new_level));
         end
      end else if (in_msg.data_one == CC_MUTE) begin
         now_muted = (in_msg.data_two != 7'd0);
         if (muted && !now_muted) expected_msgs.push_back(expression_msg(level));
         else if (!muted && now_muted) expected_msgs.push_back(expression_msg(7'd0));
         muted = now_muted;
      end else if (in_msg.data_one == CC_EXPRESSION) begin
         // dropped
      end else if (in_msg.data_one == CC_PAN && pan_owned) begin
         // dropped
      end else begin
         expected_msgs.push_back(in_msg);
      end
   endtask

   task automatic check_result(input midi_msg_t got);
      midi_msg_t want;
      results++;
      if (expected_msgs.size() == 0) begin
         $error("unexpected result transaction: %h", got);
         errors++;
         return;
      end
      want = expected_msgs.pop_front();
      if (got.status !== want.status) begin
         $error("out_status: expected %h, actual %h", want.status, got.status);
         errors++;
      end
      if (got.data_one !== want.data_one) begin
         $error("out_data_one: expected %h, actual %h", want.data_one, got.data_one);
         errors++;
      end
      if (got.data_two !== want.data_two) begin
         $error("out_data_two: expected %h, actual %h", want.data_two, got.data_two);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
      end else begin
         if (rsp_tvalid && rsp_tready) check_result(midi_msg_t'(rsp_tdata[21:0]));
         if (csr_we) begin
            if (csr_addr == CSR_CHANNEL) channel = csr_wdata;
            else pan_owned = csr_wdata[0];
         end
         if (req_tvalid && req_tready) predict_message(midi_msg_t'(req_tdata[21:0]));
      end
      error_count   <= errors;
      pending_count <= expected_msgs.size();
      result_count  <= results;
   end

endmodule

// ----- tb/tb_midi_cc_gain_mute_filter.sv -----
// Testbench top for the MIDI CC gain/mute filter: stimulus, register settings and verdict.
`timescale 1ns / 1ps

module tb_midi_cc_gain_mute_filter;
   import mcgm_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 4;
   localparam int PHASE_ITEMS    = 100;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        csr_we;
   logic [0:0]  csr_addr;
   logic [3:0]  csr_wdata;

   int error_count;
   int pending_count;
   int result_count;
   int idle_cycles = 0;
   int msgs_sent = 0;
   int settings_used = 0;
   bit req_burst = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   midi_cc_gain_mute_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   mcgm_checker filter_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count),
      .result_count  (result_count)
   );

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 92) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", idle_cycles);
         $display("FAILURE");
         $finish;
      end
   end

   // result side back-pressure
   initial begin
      int stall_left;
      bit rsp_burst;
      stall_left = 0;
      rsp_burst  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 299) == 0) rsp_burst = !rsp_burst;
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = 1'b1;
            if (!rsp_burst && $urandom_range(0, 99) < 25) stall_left = pick_gap();
         end
      end
   end

   task automatic send_msg(input logic [7:0] st, input logic [6:0] d1, input logic [6:0] d2);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {2'b00, d2, d1, st};
      do @(posedge clock); while (!req_tready);
      msgs_sent++;
   endtask

   task automatic sender_pause();
      int n;
      n = 0;
      if (!req_burst && $urandom_range(0, 99) < 45) n = pick_gap();
      if (n > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // wait for every expected result, then let dropped messages finish in the block
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(input logic [0:0] addr, input logic [3:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_addr  = addr;
      csr_wdata = data;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   task automatic apply_setting(input logic [3:0] chan, input logic pan);
      write_reg(CSR_CHANNEL, chan);
      write_reg(CSR_OWNS_PAN, {3'd0, pan});
      settings_used++;
   endtask

   function automatic logic [6:0] pick_gain_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 7'd0;
      if (r < 30) return LEVEL_MAX;
      if (r < 65) return 7'($urandom_range(90, 127));
      return 7'($urandom_range(0, 127));
   endfunction

   task automatic send_random_msg();
      logic [7:0] st;
      logic [6:0] d1;
      logic [6:0] d2;
      int r;
      r  = $urandom_range(0, 99);
      st = STATUS_CC | 8'($urandom_range(0, 15));
      d2 = 7'($urandom_range(0, 127));
      if (r < 45) begin
         d1 = CC_GAIN_FIRST + 7'($urandom_range(0, 3));
         d2 = pick_gain_value();
      end else if (r < 60) begin
         d1 = CC_MUTE;
         if ($urandom_range(0, 1)) d2 = 7'd0;
      end else if (r < 68) begin
         d1 = CC_EXPRESSION;
      end else if (r < 78) begin
         d1 = CC_PAN;
      end else if (r < 89) begin
         d1 = 7'($urandom_range(0, 127));
      end else begin
         st = 8'($urandom_range(0, 255));
         d1 = 7'($urandom_range(0, 127));
      end
      send_msg(st, d1, d2);
   endtask

   initial begin
      logic [3:0] chan;
      logic       pan;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_addr   = CSR_CHANNEL;
      csr_wdata  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      apply_setting(4'd3, 1'b0);
      send_msg(8'h00, 7'h00, 7'h00);
      send_msg(8'hff, 7'h7f, 7'h7f);
      send_msg(8'h9c, CC_GAIN_FIRST, 7'h7f);
      send_msg(8'hb3, 7'h07, 7'h40);
      send_msg(8'hb0, CC_EXPRESSION, 7'h55);
      send_msg(8'hb0, CC_PAN, 7'h40);
      send_msg(8'hb0, CC_MUTE - 7'd1, 7'h01);
      send_msg(8'hb0, CC_GAIN_LAST + 7'd1, 7'h7e);
      send_msg(8'hb0, CC_GAIN_FIRST, 7'h00);
      send_msg(8'hb1, CC_GAIN_FIRST + 7'd1, 7'h05);   // level unchanged
      send_msg(8'hb2, CC_GAIN_FIRST, 7'h7f);
      send_msg(8'hb0, CC_MUTE, 7'h01);
      send_msg(8'hb0, CC_MUTE, 7'h7f);                // already muted
      send_msg(8'hb0, CC_GAIN_FIRST + 7'd1, 7'h7f);   // gain while muted
      send_msg(8'hb0, CC_MUTE, 7'h00);                // resends old level
      send_msg(8'hb0, CC_MUTE, 7'h00);
      send_msg(8'hb0, CC_GAIN_FIRST + 7'd2, 7'h40);
      send_msg(8'hb0, CC_GAIN_LAST, 7'h7f);
      send_msg(8'hb0, CC_GAIN_FIRST + 7'd2, 7'h7f);
      drain();

      apply_setting(4'd15, 1'b1);
      send_msg(8'hb0, CC_PAN, 7'h7f);
      send_msg(8'hbf, CC_GAIN_LAST, 7'h00);
      send_msg(8'hbf, CC_GAIN_LAST, 7'h7f);
      send_msg(8'hb8, CC_PAN, 7'h00);
      send_msg(8'h7f, CC_PAN, 7'h00);
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         chan = (p == 0) ? 4'd0 : (p == 1) ? 4'd15 : 4'($urandom_range(0, 15));
         pan  = (p < 2) ? p[0] : 1'($urandom_range(0, 1));
         apply_setting(chan, pan);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
            sender_pause();
            send_random_msg();
         end
         drain();
      end

      $display("Covered %0d MIDI messages under %0d register settings, %0d results compared.",
               msgs_sent, settings_used, result_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/mcgm_pkg.sv
rtl/core/mcgm_ctrl.sv
rtl/core/mcgm_dpath.sv
rtl/core/midi_cc_gain_mute_filter.sv
tb/mcgm_checker.sv
tb/tb_midi_cc_gain_mute_filter.sv
